// ----- sv/c2d_pkg.sv -----
package c2d_pkg;

  localparam int NTAP   = 9;
  localparam int PIX_W  = 8;
  localparam int COEF_W = 16;
  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int ACC_W  = 29;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 10;
  localparam int DIM_W  = 13;
  localparam int CFG_W  = 48;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_STRIDE       = 3'd2,
    CFG_PAD_ENABLE   = 3'd3,
    CFG_COEF_TOP     = 3'd4,
    CFG_COEF_MID     = 3'd5,
    CFG_COEF_BOT     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [2:0]       s;
    logic             pad;
  } geom_t;

  typedef logic [NTAP-1:0][COEF_W-1:0] coef_t;
  typedef logic [NTAP-1:0][PIX_W-1:0]  win_t;

  // one pixel that closes at least one output window
  typedef struct packed {
    win_t             win;
    logic [1:0]       row_ok;
    logic [1:0]       col_ok;
    logic             row_n;
    logic             row_c;
    logic             row_last;
    logic [ROW_W-1:0] row_q;
    logic             col_n;
    logic             col_c;
    logic             col_last;
    logic [ROW_W-1:0] col_q;
  } work_t;

  // stride is 1..4; divide by 3 via reciprocal, exact below 4096
  function automatic logic [ROW_W-1:0] div_stride(input logic [ROW_W-1:0] t,
                                                  input logic [2:0] s);
    logic [24:0] m;
    m = 25'(t) * 25'd2731;
    case (s)
      3'd1:    div_stride = t;
      3'd2:    div_stride = t >> 1;
      3'd3:    div_stride = m[24:13];
      default: div_stride = t >> 2;
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] mul_stride(input logic [ROW_W-1:0] q,
                                                  input logic [2:0] s);
    case (s)
      3'd1:    mul_stride = q;
      3'd2:    mul_stride = q << 1;
      3'd3:    mul_stride = q + (q << 1);
      default: mul_stride = q << 2;
    endcase
  endfunction

endpackage

// ----- sv/c2d_pix_if.sv -----
interface c2d_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

// ----- sv/c2d_res_if.sv -----
interface c2d_res_if;
  logic               valid;
  logic               ready;
  logic signed [28:0] conv_value;
  logic [11:0]        out_row;
  logic [9:0]         out_col;
  logic               frame_last;

  modport source (output valid, output conv_value, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink (input valid, input conv_value, input out_row, input out_col,
                input frame_last, output ready);
endinterface

// ----- sv/c2d_ram.sv -----
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/c2d_fifo.sv -----
module c2d_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ----- sv/c2d_front.sv -----
module c2d_front #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  c2d_pix_if.sink         in_ch,
  input  c2d_pkg::geom_t  geom,
  input  logic            q_full,
  output logic            q_push,
  output c2d_pkg::work_t  q_data
);
  import c2d_pkg::*;

  localparam int CW = $clog2(MAX_LINE_WIDTH);

  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0]    col_cnt_r, col_cnt_nxt;
  logic             s1_v_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [CW-1:0]    s1_col_r;
  logic [DIM_W-1:0] s1_tr_r, s1_tc_r;
  logic [ROW_W-1:0] s1_qr_r, s1_qc_r;
  win_t             win_r, win_nxt;

  logic             accept, oob, s1_fire, has_out;
  logic [ROW_W-1:0] row_cur;
  logic [CW-1:0]    col_cur;
  logic [DIM_W-1:0] tr, tc;
  logic [15:0]      line_rd;
  logic [ROW_W-1:0] rem_r, rem_c, s_m1;
  logic             row_n, row_c, col_n, col_c, row_last, col_last;

  assign accept = in_ch.valid & in_ch.ready;

  // input position; an out-of-range count restarts the frame
  always_comb begin
    oob = (DIM_W'(col_cnt_r) >= geom.w) || ({1'b0, row_cnt_r} >= geom.h);
    row_cur = oob ? '0 : row_cnt_r;
    col_cur = oob ? '0 : col_cnt_r;
    tr = {1'b0, row_cur} + DIM_W'(geom.pad) - DIM_W'(2);
    tc = DIM_W'(col_cur) + DIM_W'(geom.pad) - DIM_W'(2);
    if (DIM_W'(col_cur) + DIM_W'(1) == geom.w) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = ({1'b0, row_cur} + DIM_W'(1) == geom.h) ? '0 : row_cur + 1'b1;
    end else begin
      col_cnt_nxt = col_cur + 1'b1;
      row_cnt_nxt = row_cur;
    end
  end

  c2d_ram #(.WIDTH(16), .DEPTH(MAX_LINE_WIDTH)) u_lines (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col_r),
    .wdata ({s1_px_r, line_rd[15:8]}),
    .re    (accept),
    .raddr (col_cur),
    .rdata (line_rd)
  );

  // which output rows and columns close on this pixel
  always_comb begin
    s_m1  = ROW_W'(geom.s - 3'd1);
    rem_r = s1_tr_r[ROW_W-1:0] - mul_stride(s1_qr_r, geom.s);
    rem_c = s1_tc_r[ROW_W-1:0] - mul_stride(s1_qc_r, geom.s);
    row_n = !s1_tr_r[DIM_W-1] && (rem_r == '0);
    col_n = !s1_tc_r[DIM_W-1] && (rem_c == '0);
    row_c = geom.pad && !s1_tr_r[DIM_W-1] && (rem_r == s_m1)
            && ({1'b0, s1_row_r} == geom.h - DIM_W'(1));
    col_c = geom.pad && !s1_tc_r[DIM_W-1] && (rem_c == s_m1)
            && (DIM_W'(s1_col_r) == geom.w - DIM_W'(1));
    row_last = ({2'b0, s1_row_r} + 14'(geom.s)) >= ({1'b0, geom.h} + 14'(geom.pad));
    col_last = (14'(s1_col_r) + 14'(geom.s)) >= ({1'b0, geom.w} + 14'(geom.pad));
    has_out = (row_n | row_c) & (col_n | col_c);
  end

  always_comb begin
    for (int w = 0; w < 3; w++) begin
      win_nxt[w*3]   = win_r[w*3+1];
      win_nxt[w*3+1] = win_r[w*3+2];
    end
    win_nxt[2] = line_rd[7:0];
    win_nxt[5] = line_rd[15:8];
    win_nxt[8] = s1_px_r;
  end

  assign s1_fire     = s1_v_r & (~has_out | ~q_full);
  assign in_ch.ready = ~s1_v_r | s1_fire;
  assign q_push      = s1_fire & has_out;

  always_comb begin
    q_data.win      = win_nxt;
    q_data.row_ok   = {s1_row_r != '0, s1_row_r >= ROW_W'(2)};
    q_data.col_ok   = {s1_col_r != '0, s1_col_r >= CW'(2)};
    q_data.row_n    = row_n;
    q_data.row_c    = row_c;
    q_data.row_last = row_last;
    q_data.row_q    = s1_qr_r;
    q_data.col_n    = col_n;
    q_data.col_c    = col_c;
    q_data.col_last = col_last;
    q_data.col_q    = s1_qc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      s1_v_r    <= 1'b0;
      win_r     <= '0;
    end else begin
      if (accept) begin
        row_cnt_r <= row_cnt_nxt;
        col_cnt_r <= col_cnt_nxt;
      end
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (s1_fire) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r  <= in_ch.pixel;
      s1_row_r <= row_cur;
      s1_col_r <= col_cur;
      s1_tr_r  <= tr;
      s1_tc_r  <= tc;
      s1_qr_r  <= div_stride(tr[ROW_W-1:0], geom.s);
      s1_qc_r  <= div_stride(tc[ROW_W-1:0], geom.s);
    end
  end

endmodule

// ----- sv/c2d_back.sv -----
module c2d_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  c2d_pkg::work_t head,
  output logic           q_pop,
  input  c2d_pkg::coef_t coefs,
  c2d_res_if.source      out_ch
);
  import c2d_pkg::*;

  logic             busy_r, rs_r, cs_r;
  logic             rs_cur, cs_cur, step, more_col, more_row;
  logic             o_rdy, b2_rdy, b1_rdy;
  win_t             sel_pix;
  coef_t            sel_coef;
  logic [2:0]       row_full, col_full;

  logic             b1_v_r, b1_last_r;
  win_t             b1_pix_r;
  coef_t            b1_coef_r;
  logic [ROW_W-1:0] b1_row_r;
  logic [COL_W-1:0] b1_col_r;

  logic                        b2_v_r, b2_last_r;
  logic [NTAP-1:0][PROD_W-1:0] b2_prod_r, prod;
  logic [ROW_W-1:0]            b2_row_r;
  logic [COL_W-1:0]            b2_col_r;

  logic                    out_v_r, out_last_r;
  logic signed [ACC_W-1:0] out_val_r, acc;
  logic [ROW_W-1:0]        out_row_r;
  logic [COL_W-1:0]        out_col_r;

  assign o_rdy  = ~out_v_r | out_ch.ready;
  assign b2_rdy = ~b2_v_r | o_rdy;
  assign b1_rdy = ~b1_v_r | b2_rdy;
  assign step   = ~q_empty & b1_rdy;

  // walk the outputs of one item: columns first, then rows
  always_comb begin
    rs_cur   = busy_r ? rs_r : ~head.row_n;
    cs_cur   = busy_r ? cs_r : ~head.col_n;
    more_col = ~cs_cur & head.col_c;
    more_row = ~rs_cur & head.row_c;
    q_pop    = step & ~more_col & ~more_row;
  end

  always_comb begin
    logic       ok;
    logic [1:0] k, l;
    row_full = {1'b1, head.row_ok};
    col_full = {1'b1, head.col_ok};
    sel_pix  = '0;
    sel_coef = '0;
    for (int w = 0; w < 3; w++) begin
      for (int v = 0; v < 3; v++) begin
        ok = row_full[w] & col_full[v] & (2'(w) >= {1'b0, rs_cur})
             & (2'(v) >= {1'b0, cs_cur});
        k = 2'(w) - {1'b0, rs_cur};
        l = 2'(v) - {1'b0, cs_cur};
        if (ok) begin
          sel_pix[w*3+v]  = head.win[w*3+v];
          sel_coef[w*3+v] = coefs[4'({2'b0, k} * 4'd3 + {2'b0, l})];
        end
      end
    end
  end

  always_comb begin
    for (int t = 0; t < NTAP; t++) begin
      prod[t] = PROD_W'($signed({1'b0, b1_pix_r[t]}) * $signed(b1_coef_r[t]));
    end
  end

  always_comb begin
    acc = '0;
    for (int t = 0; t < NTAP; t++) begin
      acc = acc + ACC_W'($signed(b2_prod_r[t]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      rs_r    <= 1'b0;
      cs_r    <= 1'b0;
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (step) begin
        if (more_col) begin
          busy_r <= 1'b1;
          rs_r   <= rs_cur;
          cs_r   <= 1'b1;
        end else if (more_row) begin
          busy_r <= 1'b1;
          rs_r   <= 1'b1;
          cs_r   <= ~head.col_n;
        end else begin
          busy_r <= 1'b0;
        end
      end
      if (b1_rdy) begin
        b1_v_r <= step;
      end
      if (b2_rdy) begin
        b2_v_r <= b1_v_r;
      end
      if (o_rdy) begin
        out_v_r <= b2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      b1_pix_r  <= sel_pix;
      b1_coef_r <= sel_coef;
      b1_row_r  <= head.row_q + ROW_W'(rs_cur);
      b1_col_r  <= COL_W'(head.col_q + ROW_W'(cs_cur));
      b1_last_r <= (rs_cur | head.row_last) & (cs_cur | head.col_last);
    end
    if (b1_v_r && b2_rdy) begin
      b2_prod_r <= prod;
      b2_row_r  <= b1_row_r;
      b2_col_r  <= b1_col_r;
      b2_last_r <= b1_last_r;
    end
    if (b2_v_r && o_rdy) begin
      out_val_r  <= acc;
      out_row_r  <= b2_row_r;
      out_col_r  <= b2_col_r;
      out_last_r <= b2_last_r;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.conv_value = out_val_r;
  assign out_ch.out_row    = out_row_r;
  assign out_ch.out_col    = out_col_r;
  assign out_ch.frame_last = out_last_r;

endmodule

// ----- sv/conv2d_stride_pad_3x3.sv -----
// 3x3 convolution over a raster pixel stream, optional zero border, stride 1..4.
// in_ch: one 8-bit pixel per item, valid/ready, raster order.
// out_ch: one item per output position, raster order: signed 29-bit sum
//   (conv_value), output row and column, frame_last on the frame's final output.
// cfg_*: write enable, register index and data; write only while idle.
// Throughput: one pixel per cycle while the queue is not full. A pixel that closes
//   several windows (up to 4, only along the bottom/right border) yields one result
//   per window on the result side; a four-entry queue between classification and
//   arithmetic absorbs that.
// Path to out_ch: classify into queue, tap select, multiply, adder tree, each registered.
// Line buffer: one dual-port RAM of MAX_LINE_WIDTH x 16 bits, read and
//   written once per pixel.
// Reset: counters clear, pipeline empties, registers return to 3x3, stride 1,
//   padding on, zero kernel. No clearing pass.
// Stall: a held out_ch fills the pipeline and queue, then in_ch.ready drops.
module conv2d_stride_pad_3x3 #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  c2d_pix_if.sink     in_ch,
  c2d_res_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);
  import c2d_pkg::*;

  localparam int QDEPTH = 4;
  localparam logic [DIM_W-1:0] MAXW = DIM_W'(MAX_LINE_WIDTH);

  logic [10:0]      width_r;
  logic [12:0]      height_r;
  logic [2:0]       stride_r;
  logic             pad_r;
  logic [CFG_W-1:0] coef_top_r, coef_mid_r, coef_bot_r;

  geom_t geom;
  coef_t coefs;
  work_t push_data, head;
  logic  q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 11'd3;
      height_r   <= 13'd3;
      stride_r   <= 3'd1;
      pad_r      <= 1'b1;
      coef_top_r <= '0;
      coef_mid_r <= '0;
      coef_bot_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r    <= cfg_wdata[10:0];
        CFG_IMAGE_HEIGHT: height_r   <= cfg_wdata[12:0];
        CFG_STRIDE:       stride_r   <= cfg_wdata[2:0];
        CFG_PAD_ENABLE:   pad_r      <= cfg_wdata[0];
        CFG_COEF_TOP:     coef_top_r <= cfg_wdata;
        CFG_COEF_MID:     coef_mid_r <= cfg_wdata;
        CFG_COEF_BOT:     coef_bot_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (DIM_W'(width_r) < DIM_W'(3)) begin
      geom.w = DIM_W'(3);
    end else if (DIM_W'(width_r) > MAXW) begin
      geom.w = MAXW;
    end else begin
      geom.w = DIM_W'(width_r);
    end
    if (height_r < 13'd3) begin
      geom.h = 13'd3;
    end else if (height_r > 13'd4096) begin
      geom.h = 13'd4096;
    end else begin
      geom.h = height_r;
    end
    if (stride_r == 3'd0) begin
      geom.s = 3'd1;
    end else if (stride_r > 3'd4) begin
      geom.s = 3'd4;
    end else begin
      geom.s = stride_r;
    end
    geom.pad = pad_r;
    for (int l = 0; l < 3; l++) begin
      coefs[l]   = coef_top_r[16*l +: 16];
      coefs[3+l] = coef_mid_r[16*l +: 16];
      coefs[6+l] = coef_bot_r[16*l +: 16];
    end
  end

  c2d_front #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .geom   (geom),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (push_data)
  );

  c2d_fifo #(.WIDTH($bits(work_t)), .DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty)
  );

  c2d_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .head    (head),
    .q_pop   (q_pop),
    .coefs   (coefs),
    .out_ch  (out_ch)
  );

endmodule

// ----- sv/c2d_checker.sv -----
module c2d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [28:0] conv_value,
  input logic [11:0] out_row,
  input logic [9:0]  out_col,
  input logic        frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(conv_value) && $stable(out_row)
                                && $stable(out_col) && $stable(frame_last))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind conv2d_stride_pad_3x3 c2d_checker u_c2d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .conv_value (out_ch.conv_value),
  .out_row    (out_ch.out_row),
  .out_col    (out_ch.out_col),
  .frame_last (out_ch.frame_last)
);
